// ===== hdl/scdec_pkg.sv =====
// ----------------------------------------------------------------------------
// scdec_pkg
// Shared types, scancode constants and Turkish-Q translation tables for the
// set-1 scancode keyboard decoder.
// ----------------------------------------------------------------------------
package scdec_pkg;

  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_BREAK  = 8'h80;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_DOWN   = 8'h50;
  localparam logic [7:0] CH_UP     = 8'h11;
  localparam logic [7:0] CH_DOWN   = 8'h12;
  localparam logic [7:0] MAP_LEN   = 8'd58;

  localparam logic       ACT_SCAN  = 1'b0;
  localparam logic       ACT_READ  = 1'b1;
  localparam logic       KIND_SHELL = 1'b0;
  localparam logic       KIND_READ  = 1'b1;

  localparam logic [7:0] MAP_PLAIN [0:57] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2A, 8'h2D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h67, 8'h81, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h73,
    8'h69, 8'h22, 8'h00, 8'h2C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h94, 8'h87, 8'h2E, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] MAP_SHIFTED [0:57] = '{
    8'h00, 8'h1B, 8'h21, 8'h27, 8'h5E, 8'h2B, 8'h25, 8'h26, 8'h2F, 8'h28,
    8'h29, 8'h3D, 8'h3F, 8'h5F, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h47, 8'h9A, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h53,
    8'h49, 8'h27, 8'h00, 8'h3B, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h99, 8'h80, 8'h3A, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Decision for one scancode item.
  typedef struct packed {
    logic       shift_set;
    logic       shift_clr;
    logic       shell;
    logic       push;
    logic [7:0] ch;
  } dec_t;

  // FIFO status seen by the control logic.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// ===== hdl/scdec_translate.sv =====
// ----------------------------------------------------------------------------
// scdec_translate
// Decodes one set-1 scancode into a shift update, a shell character or a
// character for the buffer.
// ----------------------------------------------------------------------------
module scdec_translate (
  input  logic [7:0]       code,
  input  logic             shift_flag,
  input  logic             shell_mode,
  output scdec_pkg::dec_t  dec
);
  import scdec_pkg::*;

  logic [7:0] tab_ch;

  always_comb begin
    if (shift_flag) begin
      tab_ch = MAP_SHIFTED[code[5:0]];
    end else begin
      tab_ch = MAP_PLAIN[code[5:0]];
    end
  end

  always_comb begin
    dec = '0;
    priority if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      dec.shift_set = 1'b1;
    end else if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
      dec.shift_clr = 1'b1;
    end else if ((code & SC_BREAK) != 8'h00) begin
      dec = '0;
    end else if (code == SC_UP) begin
      dec.shell = 1'b1;
      dec.ch    = CH_UP;
    end else if (code == SC_DOWN) begin
      dec.shell = 1'b1;
      dec.ch    = CH_DOWN;
    end else if (code >= MAP_LEN) begin
      dec = '0;
    end else begin
      // Zero table entries have no character and produce nothing.
      dec.ch    = tab_ch;
      dec.shell = (tab_ch != 8'h00) && shell_mode;
      dec.push  = (tab_ch != 8'h00) && !shell_mode;
    end
  end

endmodule

// ===== hdl/scdec_fifo.sv =====
// ----------------------------------------------------------------------------
// scdec_fifo
// Ring buffer of characters with registered read data. One slot is kept
// free, so it holds DEPTH - 1 characters.
// ----------------------------------------------------------------------------
module scdec_fifo #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            push_data,
  input  logic                  pop,
  output logic [7:0]            rdata,
  output scdec_pkg::fifo_stat_t stat
);
  import scdec_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [7:0]    mem [0:DEPTH-1];
  logic [PW-1:0] write_ptr;
  logic [PW-1:0] read_ptr;
  logic [PW-1:0] write_ptr_next;
  logic [PW-1:0] read_ptr_next;

  assign write_ptr_next = (write_ptr == LAST) ? '0 : write_ptr + 1'b1;
  assign read_ptr_next  = (read_ptr == LAST) ? '0 : read_ptr + 1'b1;

  assign stat.empty = (write_ptr == read_ptr);
  assign stat.full  = (write_ptr_next == read_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      if (push) begin
        write_ptr <= write_ptr_next;
      end
      if (pop) begin
        read_ptr <= read_ptr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[write_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= mem[read_ptr];
    end
  end

endmodule

// ===== hdl/scancode_set1_keyboard_decoder_core.sv =====
// ----------------------------------------------------------------------------
// scancode_set1_keyboard_decoder_core
// Set-1 scancode to Turkish-Q character decoder with a character buffer.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while in_stall is low. An accepted item sits in the
// input register, where the table lookup and the buffer access happen, and its
// result, if any, then moves to the output register, which also holds the
// registered buffer read, and is offered at the output from there. A stalled
// result blocks a new item only when the item in the input register has a
// result of its own. The buffer holds FIFO_DEPTH - 1 characters; characters
// arriving when it is full are dropped. Arrow keys always go to the shell,
// whatever shell_mode says.
module scancode_set1_keyboard_decoder_core #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic [7:0] char_code,
  output logic       empty_res
);
  import scdec_pkg::*;

  logic       shell_mode;
  logic       shift_flag;

  logic       a_valid;
  logic       a_action;
  logic [7:0] a_code;
  logic       a_result;
  logic       a_adv;
  logic       accept;

  logic       b_valid;
  logic       b_kind;
  logic       b_empty;
  logic       b_from_fifo;
  logic [7:0] b_char;

  dec_t       dec;
  fifo_stat_t stat;
  logic       push;
  logic       pop;
  logic [7:0] rdata;

  scdec_translate u_translate (
    .code       (a_code),
    .shift_flag (shift_flag),
    .shell_mode (shell_mode),
    .dec        (dec)
  );

  scdec_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (dec.ch),
    .pop       (pop),
    .rdata     (rdata),
    .stat      (stat)
  );

  assign a_result = (a_action == ACT_READ) || dec.shell;
  assign a_adv    = a_valid && (!a_result || !b_valid || !out_stall);
  assign in_stall = a_valid && !a_adv;
  assign accept   = in_valid && !in_stall;

  assign push = a_adv && (a_action == ACT_SCAN) && dec.push && !stat.full;
  assign pop  = a_adv && (a_action == ACT_READ) && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      shell_mode <= 1'b0;
    end else if (cfg_write_en) begin
      shell_mode <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag <= 1'b0;
    end else if (a_adv && (a_action == ACT_SCAN)) begin
      if (dec.shift_set) begin
        shift_flag <= 1'b1;
      end else if (dec.shift_clr) begin
        shift_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_action <= action;
      a_code   <= scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv && a_result) begin
      b_valid <= 1'b1;
    end else if (!out_stall) begin
      b_valid <= 1'b0;
    end
  end

  // The buffer read data lands in the same edge as this load, so the output
  // picks it up whenever the item was a successful read.
  always_ff @(posedge clk) begin
    if (a_adv && a_result) begin
      b_kind      <= (a_action == ACT_READ) ? KIND_READ : KIND_SHELL;
      b_empty     <= (a_action == ACT_READ) && stat.empty;
      b_from_fifo <= (a_action == ACT_READ) && !stat.empty;
      b_char      <= (a_action == ACT_READ) ? 8'h00 : dec.ch;
    end
  end

  assign out_valid = b_valid;
  assign kind      = b_kind;
  assign empty_res = b_empty;
  assign char_code = b_from_fifo ? rdata : b_char;

endmodule

// ===== hdl/scdec_checker.sv =====
// ----------------------------------------------------------------------------
// scdec_checker
// Port-level checks for the scancode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module scdec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] char_code,
  input logic       empty_res
);
  import scdec_pkg::*;

  // An empty read always reports a zero character as a read response.
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> (kind == KIND_READ) && (char_code == 8'h00))
    else $error("empty read response with bad kind or character");

  // A shell delivery always carries a real character and no empty flag.
  a_shell_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_SHELL) |-> (char_code != 8'h00) && !empty_res)
    else $error("shell delivery with zero character or empty flag");

  // Input is only held off while a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(char_code)
      && $stable(empty_res))
    else $error("stalled result changed");

endmodule

bind scancode_set1_keyboard_decoder_core scdec_checker u_scdec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .char_code (char_code),
  .empty_res (empty_res)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-1 scancode decoder. A directed table is
// run first, then keystroke sequences with random content, reads and noise.
// Every result is checked against the directed row's expected result or a
// local model of the shift flag, the translation tables and the character
// buffer. Both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb;
  import scdec_pkg::*;

  localparam int DEPTH       = 256;
  localparam int KEY_COUNT   = 58;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       empty;
  } char_res_t;

  typedef enum {CHK_PRED, CHK_RES, CHK_NONE} row_check_t;

  typedef struct {
    logic       act;
    logic [7:0] code;
    row_check_t how;
    char_res_t  res;
  } dir_row_t;

  localparam char_res_t NO_RES     = '0;
  localparam char_res_t EMPTY_READ = '{KIND_READ, 8'h00, 1'b1};
  localparam char_res_t UP_SHELL   = '{KIND_SHELL, CH_UP, 1'b0};
  localparam char_res_t DOWN_SHELL = '{KIND_SHELL, CH_DOWN, 1'b0};

  // Turkish-Q layout, unshifted and shifted, indexed by make code.
  localparam bit [7:0] KEYS_PLAIN [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2A, 8'h2D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h67, 8'h81, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h73,
    8'h69, 8'h22, 8'h00, 8'h2C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h94, 8'h87, 8'h2E, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam bit [7:0] KEYS_SHIFT [KEY_COUNT] = '{
    8'h00, 8'h1B, 8'h21, 8'h27, 8'h5E, 8'h2B, 8'h25, 8'h26, 8'h2F, 8'h28,
    8'h29, 8'h3D, 8'h3F, 8'h5F, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h47, 8'h9A, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h53,
    8'h49, 8'h27, 8'h00, 8'h3B, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h99, 8'h80, 8'h3A, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Directed items, run with shell_mode 0 straight after reset.
  dir_row_t dir_rows [25] = '{
    '{ACT_READ, 8'h00, CHK_RES, EMPTY_READ},
    '{ACT_SCAN, SC_UP, CHK_RES, UP_SHELL},
    '{ACT_SCAN, SC_DOWN, CHK_RES, DOWN_SHELL},
    '{ACT_SCAN, 8'h00, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'hFF, CHK_NONE, NO_RES},
    '{ACT_SCAN, MAP_LEN, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'h7F, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'h10, CHK_PRED, NO_RES},
    '{ACT_SCAN, SC_LSHIFT, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'h10, CHK_PRED, NO_RES},
    '{ACT_SCAN, SC_LSHIFT | SC_BREAK, CHK_NONE, NO_RES},
    '{ACT_SCAN, SC_RSHIFT, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'h39, CHK_PRED, NO_RES},
    '{ACT_SCAN, SC_RSHIFT | SC_BREAK, CHK_NONE, NO_RES},
    '{ACT_SCAN, 8'h01, CHK_PRED, NO_RES},
    '{ACT_SCAN, SC_BREAK, CHK_NONE, NO_RES},
    '{ACT_SCAN, SC_UP | SC_BREAK, CHK_NONE, NO_RES},
    '{ACT_READ, 8'h00, CHK_PRED, NO_RES},
    '{ACT_READ, 8'h00, CHK_PRED, NO_RES},
    '{ACT_READ, 8'h00, CHK_PRED, NO_RES},
    '{ACT_READ, 8'h00, CHK_PRED, NO_RES},
    '{ACT_READ, 8'h00, CHK_RES, EMPTY_READ},
    '{ACT_READ, 8'hFF, CHK_RES, EMPTY_READ},
    '{ACT_SCAN, 8'h1B, CHK_PRED, NO_RES},
    '{ACT_READ, 8'hA5, CHK_PRED, NO_RES}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic       cfg_write_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       action = 1'b0;
  logic [7:0] scan_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] char_code;
  logic       empty_res;

  // Model state.
  bit         shell_on;
  bit         shift_on;
  bit [7:0]   char_store [DEPTH];
  int         wr_idx;
  int         rd_idx;

  char_res_t  char_expect [$];

  int         err_count;
  int         items_sent;
  int         results_checked;
  int         shell_seen;
  int         empty_reads;
  int         full_drops;
  int         cfg_writes;
  bit         quiet;
  int         stall_left;

  scancode_set1_keyboard_decoder_core #(.FIFO_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .scan_byte      (scan_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .char_code      (char_code),
    .empty_res      (empty_res)
  );

  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

  // Works out the result of one accepted item and advances the model state.
  function automatic bit decode_item(input logic act, input logic [7:0] code,
                                     output char_res_t r);
    bit [7:0] c;
    int       nxt;
    r = NO_RES;
    if (act == ACT_READ) begin
      if (wr_idx == rd_idx) begin
        r = EMPTY_READ;
        empty_reads++;
        return 1'b1;
      end
      r = '{KIND_READ, char_store[rd_idx], 1'b0};
      rd_idx = (rd_idx + 1) % DEPTH;
      return 1'b1;
    end
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_on = 1'b1;
      return 1'b0;
    end
    if (code == (SC_LSHIFT | SC_BREAK) || code == (SC_RSHIFT | SC_BREAK)) begin
      shift_on = 1'b0;
      return 1'b0;
    end
    if ((code & SC_BREAK) != 8'h00) return 1'b0;
    if (code == SC_UP) begin
      r = UP_SHELL;
      return 1'b1;
    end
    if (code == SC_DOWN) begin
      r = DOWN_SHELL;
      return 1'b1;
    end
    if (code >= MAP_LEN) return 1'b0;
    c = shift_on ? KEYS_SHIFT[code] : KEYS_PLAIN[code];
    if (c == 8'h00) return 1'b0;
    if (shell_on) begin
      r = '{KIND_SHELL, c, 1'b0};
      return 1'b1;
    end
    nxt = (wr_idx + 1) % DEPTH;
    // A full buffer drops the new character.
    if (nxt == rd_idx) begin
      full_drops++;
      return 1'b0;
    end
    char_store[wr_idx] = c;
    wr_idx = nxt;
    return 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int send_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return gap_len();
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 5) return $urandom_range(0, 1) ? SC_UP : SC_DOWN;
    return 8'($urandom_range(0, KEY_COUNT - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic act, input logic [7:0] code,
                           input row_check_t how, input char_res_t typed);
    int        gap;
    bit        has;
    char_res_t pr;
    gap = send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    scan_byte <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_item(act, code, pr);
    case (how)
      CHK_PRED: begin
        if (has) char_expect.push_back(pr);
      end
      CHK_RES: begin
        char_expect.push_back(typed);
      end
      default: begin
      end
    endcase
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic act, input logic [7:0] code);
    send_item(act, code, CHK_PRED, NO_RES);
  endtask

  // Holds the sender off until every expected result has come, then lets
  // extra cycles pass for items that are still in flight without a result.
  task automatic wait_drained(input int extra);
    int n;
    in_valid <= 1'b0;
    n = 0;
    @(negedge clk);
    while (char_expect.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (char_expect.size() != 0) begin
      err_count += char_expect.size();
      $display("tb: %0d expected results never arrived", char_expect.size());
      char_expect.delete();
    end
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_shell_mode(input bit v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    shell_on = v;
    cfg_writes++;
  endtask

  task automatic type_key(input bit shifted, input logic [7:0] key);
    logic [7:0] sh;
    sh = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    if (shifted) put(ACT_SCAN, sh);
    put(ACT_SCAN, key);
    put(ACT_SCAN, key | SC_BREAK);
    if (shifted) put(ACT_SCAN, sh | SC_BREAK);
  endtask

  // Sends about n items, pausing once halfway until all results are in.
  task automatic run_phase(input int n, input int read_pct, input int noise_pct);
    int start;
    int next_quiet;
    int r;
    bit drained;
    start      = items_sent;
    next_quiet = 0;
    drained    = 1'b0;
    while (items_sent - start < n) begin
      if (items_sent - start >= next_quiet) begin
        quiet = ($urandom_range(0, 3) == 0);
        next_quiet += 40;
      end
      if (!drained && items_sent - start >= n / 2) begin
        wait_drained(4);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < read_pct) begin
        put(ACT_READ, 8'($urandom_range(0, 255)));
      end else if (r < read_pct + noise_pct) begin
        put(ACT_SCAN, 8'($urandom_range(0, 255)));
      end else begin
        type_key($urandom_range(0, 2) == 0, pick_key());
      end
    end
  endtask

  // Make codes of letter keys only and no reads, so every item adds a
  // character and the buffer overruns.
  task automatic fill_buffer(input int n);
    for (int i = 0; i < n; i++) put(ACT_SCAN, 8'(8'h10 + i % 10));
  endtask

  // Receiver throttle: random stalls of mixed length, none started while quiet.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = gap_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    char_res_t got;
    char_res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {kind, char_code, empty_res};
      if (char_expect.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("tb: unexpected result kind=%0d char=%02h empty=%0d",
                   got.kind, got.ch, got.empty);
      end else begin
        want = char_expect.pop_front();
        results_checked++;
        if (want.kind == KIND_SHELL) shell_seen++;
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"tb: mismatch expected kind=%0d char=%02h empty=%0d,",
                      " got kind=%0d char=%02h empty=%0d"},
                     want.kind, want.ch, want.empty, got.kind, got.ch, got.empty);
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_shell_mode(1'b0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].code, dir_rows[i].how, dir_rows[i].res);
    wait_drained(4);

    run_phase(60, 25, 10);
    wait_drained(4);
    set_shell_mode(1'b1);
    run_phase(50, 20, 15);
    wait_drained(4);
    set_shell_mode(1'b0);
    // Typing with no reads overruns the buffer.
    fill_buffer(280);
    run_phase(110, 70, 10);
    wait_drained(4);
    set_shell_mode(1'b1);
    run_phase(30, 30, 10);
    wait_drained(6);

    $display("tb: %0d items sent, %0d results checked, %0d shell deliveries",
             items_sent, results_checked, shell_seen);
    $display("tb: %0d empty-buffer reads, %0d characters dropped when full, %0d mode writes",
             empty_reads, full_drops, cfg_writes);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
